@@ rtl/sdtq_pkg.sv @@
package sdtq_pkg;

   localparam int POOL_DEPTH = 16;
   localparam int MAX_FIRE   = 16;
   localparam int ID_W       = 8;
   localparam int TIME_W     = 32;
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int FIRE_W     = $clog2(MAX_FIRE + 1);

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_POP    = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type      cmd;
      logic [ID_W-1:0]   key_id;
      logic [TIME_W-1:0] key_deadline;
   } cell_ctrl_type;

   typedef struct packed {
      logic      found;
      logic      head_due;
      entry_type head;
   } chain_status_type;

endpackage

@@ rtl/sdtq_cell.sv @@
module sdtq_cell (
   input  logic                   clock,
   input  sdtq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_gt,
   input  logic                   take_right,
   input  sdtq_pkg::entry_type    left_entry,
   input  sdtq_pkg::entry_type    right_entry,
   output sdtq_pkg::entry_type    entry,
   output logic                   gt,
   output logic                   hit
);
   import sdtq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // an empty slot counts as later than any deadline, so it takes the new entry
   assign gt    = !occupied || (entry_ff.deadline > ctrl.key_deadline);
   assign hit   = occupied && (entry_ff.id == ctrl.key_id);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
            end else if (gt) begin
               entry_in.id       = ctrl.key_id;
               entry_in.deadline = ctrl.key_deadline;
            end
         end
         CELL_REMOVE, CELL_POP: begin
            if (take_right) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/sdtq_chain.sv @@
module sdtq_chain (
   input  logic                         clock,
   input  sdtq_pkg::cell_ctrl_type       ctrl,
   input  logic [sdtq_pkg::CNT_W-1:0]    count,
   output sdtq_pkg::chain_status_type    status
);
   import sdtq_pkg::*;

   entry_type              entries [POOL_DEPTH];
   logic [POOL_DEPTH-1:0]  gt;
   logic [POOL_DEPTH-1:0]  hit;
   logic [POOL_DEPTH-1:0]  occupied;
   logic [POOL_DEPTH-1:0]  take_right;

   genvar i;
   generate
      for (i = 0; i < POOL_DEPTH; i++) begin : g_cell
         entry_type left_entry;
         entry_type right_entry;
         logic      left_gt;

         assign occupied[i] = (CNT_W'(i) < count);
         // shift left from the matching slot onwards, or everything on a pop
         assign take_right[i] = (ctrl.cmd == CELL_POP) || (|hit[i:0]);

         if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_gt    = 1'b0;
         end else begin : g_mid
            assign left_entry = entries[i-1];
            assign left_gt    = gt[i-1];
         end

         if (i == POOL_DEPTH - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = entries[i+1];
         end

         sdtq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[i]),
            .left_gt     (left_gt),
            .take_right  (take_right[i]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .gt          (gt[i]),
            .hit         (hit[i])
         );
      end
   endgenerate

   assign status.found    = |hit;
   assign status.head_due = !gt[0];
   assign status.head     = entries[0];

endmodule

@@ rtl/sorted_deadline_timer_queue.sv @@
// Sorted deadline timer queue.
// Request channel (req_valid / req_stall) carries an opcode, a timer id and a
// time value: create or rearm a timer, delete a timer, or tick with the
// current time. Pending timers sit in a row of cells in deadline order; a
// create, delete or pop shifts the cells behind the affected slot by one place.
// Response channel (rsp_valid / rsp_stall) returns one response per create,
// delete, unused opcode or idle tick, and one per fired timer on a tick, with
// rsp_last set on the final one of a request. Each response carries the earliest
// deadline and the empty flag as they stand after it.
// One request is handled at a time; req_stall is high until its last
// response has been taken. After acceptance a create passes through the
// remove, insert and emit states, a delete through remove and emit, a tick
// through tick and emit, and an unused opcode straight to emit; each further
// expiry of a tick goes back through tick and emit. A stalled response
// holds its payload and the queue is frozen.
// Synchronous reset empties the queue at once and drops any response.
module sorted_deadline_timer_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [sdtq_pkg::ID_W-1:0]     req_timer_id,
   input  logic [sdtq_pkg::TIME_W-1:0]   req_time_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic                          rsp_expired_valid,
   output logic [sdtq_pkg::ID_W-1:0]     rsp_expired_id,
   output logic                          rsp_last,
   output logic                          rsp_queue_empty,
   output logic [sdtq_pkg::TIME_W-1:0]   rsp_earliest_deadline
);
   import sdtq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REMOVE = 6'b000010,
      S_INSERT = 6'b000100,
      S_TICK   = 6'b001000,
      S_EMIT   = 6'b010000,
      S_WAIT   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FIRE_W-1:0]   fire_cnt_ff, fire_cnt_in;
   logic                exp_valid_ff, exp_valid_in;
   logic [ID_W-1:0]     exp_id_ff, exp_id_in;
   logic                status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_exp_valid_ff, rsp_exp_valid_in;
   logic [ID_W-1:0]     rsp_exp_id_ff, rsp_exp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [TIME_W-1:0]   rsp_deadline_ff, rsp_deadline_in;

   cell_ctrl_type       ctrl;
   chain_status_type    chain_st;
   logic                full;
   logic                can_fire;

   assign full     = (count_ff == CNT_W'(POOL_DEPTH));
   assign can_fire = chain_st.head_due && (fire_cnt_ff < FIRE_W'(MAX_FIRE));

   always_comb begin
      ctrl.key_id       = id_ff;
      ctrl.key_deadline = time_ff;
      ctrl.cmd          = CELL_HOLD;
      case (state_ff)
         S_REMOVE: ctrl.cmd = CELL_REMOVE;
         S_INSERT: ctrl.cmd = full ? CELL_HOLD : CELL_INSERT;
         S_TICK:   ctrl.cmd = can_fire ? CELL_POP : CELL_HOLD;
         default:  ctrl.cmd = CELL_HOLD;
      endcase
   end

   sdtq_chain u_chain (
      .clock  (clock),
      .ctrl   (ctrl),
      .count  (count_ff),
      .status (chain_st)
   );

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      time_in          = time_ff;
      count_in         = count_ff;
      fire_cnt_in      = fire_cnt_ff;
      exp_valid_in     = exp_valid_ff;
      exp_id_in        = exp_id_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_exp_valid_in = rsp_exp_valid_ff;
      rsp_exp_id_in    = rsp_exp_id_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_deadline_in  = rsp_deadline_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_opcode;
               id_in        = req_timer_id;
               time_in      = req_time_value;
               fire_cnt_in  = '0;
               exp_valid_in = 1'b0;
               exp_id_in    = '0;
               status_in    = 1'b0;
               if (req_opcode == OP_CREATE || req_opcode == OP_DELETE) begin
                  state_in = S_REMOVE;
               end else if (req_opcode == OP_TICK) begin
                  state_in = S_TICK;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_REMOVE: begin
            if (chain_st.found) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = (op_ff == OP_CREATE) ? S_INSERT : S_EMIT;
         end
         S_INSERT: begin
            // no same id was freed and the pool is full: report and drop
            if (full) begin
               status_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_EMIT;
         end
         S_TICK: begin
            if (can_fire) begin
               exp_valid_in = 1'b1;
               exp_id_in    = chain_st.head.id;
               count_in     = count_ff - CNT_W'(1);
               fire_cnt_in  = fire_cnt_ff + FIRE_W'(1);
            end else begin
               exp_valid_in = 1'b0;
               exp_id_in    = '0;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = status_ff;
            rsp_exp_valid_in = exp_valid_ff;
            rsp_exp_id_in    = exp_id_ff;
            // a tick goes on while the new head is due and the burst limit allows
            rsp_last_in      = (op_ff == OP_TICK && exp_valid_ff) ? !can_fire : 1'b1;
            rsp_empty_in     = (count_ff == '0);
            rsp_deadline_in  = (count_ff == '0) ? '0 : chain_st.head.deadline;
            state_in         = S_WAIT;
         end
         S_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? S_IDLE : S_TICK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff            <= op_in;
      id_ff            <= id_in;
      time_ff          <= time_in;
      fire_cnt_ff      <= fire_cnt_in;
      exp_valid_ff     <= exp_valid_in;
      exp_id_ff        <= exp_id_in;
      status_ff        <= status_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_exp_valid_ff <= rsp_exp_valid_in;
      rsp_exp_id_ff    <= rsp_exp_id_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_deadline_ff  <= rsp_deadline_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_expired_valid     = rsp_exp_valid_ff;
   assign rsp_expired_id        = rsp_exp_id_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_queue_empty       = rsp_empty_ff;
   assign rsp_earliest_deadline = rsp_deadline_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_DEPTH))
      else $error("timer count beyond pool depth");

   a_rsp_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_WAIT))
      else $error("response valid outside wait state");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> full)
      else $error("pool full reported with free slot");

   a_fire_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exp_valid_ff) |-> (fire_cnt_ff != '0))
      else $error("expiry reported without a counted fire");
`endif

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sdtq_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         TAIL_CYCLES = 20;
   localparam int         HOLD_CYCLES = 300;
   localparam int         HOLD_AFTER  = 60;
   localparam int         NUM_RANDOM  = 141;

   typedef struct {
      logic [1:0]        op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] tval;
      int                gap;
      bit                drain;
   } timer_req_type;

   typedef struct packed {
      logic              status;
      logic              expired_valid;
      logic [ID_W-1:0]   expired_id;
      logic              last;
      logic              queue_empty;
      logic [TIME_W-1:0] earliest_deadline;
   } timer_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_TICK;
   logic [ID_W-1:0]     req_timer_id = '0;
   logic [TIME_W-1:0]   req_time_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_status;
   logic                rsp_expired_valid;
   logic [ID_W-1:0]     rsp_expired_id;
   logic                rsp_last;
   logic                rsp_queue_empty;
   logic [TIME_W-1:0]   rsp_earliest_deadline;

   // predictor state: pending timers in deadline order
   logic [TIME_W-1:0]   pend_deadline [POOL_DEPTH];
   logic [ID_W-1:0]     pend_id [POOL_DEPTH];
   int                  pend_count = 0;

   timer_req_type       req_backlog [$];
   timer_rsp_type       timer_outcomes [$];
   timer_req_type       next_req;

   int                  idle_left = -1;
   int                  stall_left = 0;
   int                  resp_count = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   logic                hold_on = 1'b0;
   logic                hold_done = 1'b0;
   int                  hold_cycles = 0;

   // stimulus shaping
   logic [TIME_W-1:0]   now_time;
   logic [TIME_W-1:0]   last_deadline;

   sorted_deadline_timer_queue dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_timer_id          (req_timer_id),
      .req_time_value        (req_time_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_expired_valid     (rsp_expired_valid),
      .rsp_expired_id        (rsp_expired_id),
      .rsp_last              (rsp_last),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_earliest_deadline (rsp_earliest_deadline)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("sorted_deadline_timer_queue verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int find_timer(logic [ID_W-1:0] id);
      for (int i = 0; i < pend_count; i++)
         if (pend_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_timer(int pos);
      for (int i = pos; i < pend_count - 1; i++) begin
         pend_id[i]       = pend_id[i+1];
         pend_deadline[i] = pend_deadline[i+1];
      end
      pend_count--;
   endfunction

   function automatic void insert_timer(logic [ID_W-1:0] id, logic [TIME_W-1:0] dl);
      int pos;
      pos = 0;
      // equal deadlines: go behind the older ones
      while (pos < pend_count && pend_deadline[pos] <= dl) pos++;
      for (int i = pend_count; i > pos; i--) begin
         pend_id[i]       = pend_id[i-1];
         pend_deadline[i] = pend_deadline[i-1];
      end
      pend_id[pos]       = id;
      pend_deadline[pos] = dl;
      pend_count++;
   endfunction

   function automatic void record_outcome(logic st, logic ev, logic [ID_W-1:0] eid,
                                          logic lst);
      timer_rsp_type r;
      r.status            = st;
      r.expired_valid     = ev;
      r.expired_id        = eid;
      r.last              = lst;
      r.queue_empty       = (pend_count == 0);
      r.earliest_deadline = (pend_count == 0) ? '0 : pend_deadline[0];
      timer_outcomes.push_back(r);
   endfunction

   function automatic void apply_timer_request(logic [1:0] op, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] tval);
      int        idx;
      int        fired;
      logic      full_fail;
      logic      more;
      logic [ID_W-1:0] fid;
      fired     = 0;
      full_fail = 1'b0;
      case (op)
         OP_CREATE: begin
            idx = find_timer(id);
            if (idx >= 0) drop_timer(idx);
            if (idx < 0 && pend_count >= POOL_DEPTH) full_fail = 1'b1;
            else insert_timer(id, tval);
            record_outcome(full_fail, 1'b0, '0, 1'b1);
         end
         OP_DELETE: begin
            idx = find_timer(id);
            if (idx >= 0) drop_timer(idx);
            record_outcome(1'b0, 1'b0, '0, 1'b1);
         end
         OP_TICK: begin
            more = (pend_count > 0 && pend_deadline[0] <= tval);
            if (!more) record_outcome(1'b0, 1'b0, '0, 1'b1);
            while (more) begin
               fid = pend_id[0];
               drop_timer(0);
               fired++;
               more = (pend_count > 0 && pend_deadline[0] <= tval && fired < MAX_FIRE);
               record_outcome(1'b0, 1'b1, fid, !more);
            end
         end
         default: record_outcome(1'b0, 1'b0, '0, 1'b1);
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = -1;
      end else begin
         if (req_valid && !req_stall)
            apply_timer_request(req_opcode, req_timer_id, req_time_value);
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               if (idle_left < 0) idle_left = req_backlog[0].gap;
               if (idle_left > 0) begin
                  idle_left--;
                  req_valid <= 1'b0;
               end else if (req_backlog[0].drain && timer_outcomes.size() != 0) begin
                  // hold until every outstanding response has come back
                  req_valid <= 1'b0;
               end else begin
                  next_req = req_backlog.pop_front();
                  req_opcode     <= next_req.op;
                  req_timer_id   <= next_req.id;
                  req_time_value <= next_req.tval;
                  req_valid      <= 1'b1;
                  idle_left = -1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      timer_rsp_type got;
      timer_rsp_type want;
      logic          bad;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status            = rsp_status;
            got.expired_valid     = rsp_expired_valid;
            got.expired_id        = rsp_expired_id;
            got.last              = rsp_last;
            got.queue_empty       = rsp_queue_empty;
            got.earliest_deadline = rsp_earliest_deadline;
            if (timer_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"unexpected response: st=%0d ev=%0d id=%02h last=%0d",
                            " empty=%0d dl=%08h"},
                           got.status, got.expired_valid, got.expired_id, got.last,
                           got.queue_empty, got.earliest_deadline);
            end else begin
               want = timer_outcomes.pop_front();
               bad  = (got.status !== want.status) ||
                      (got.expired_valid !== want.expired_valid) ||
                      (got.expired_id !== want.expired_id) ||
                      (got.last !== want.last) ||
                      (got.queue_empty !== want.queue_empty) ||
                      (got.earliest_deadline !== want.earliest_deadline);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"response %0d: want st=%0d ev=%0d id=%02h last=%0d",
                               " empty=%0d dl=%08h, got st=%0d ev=%0d id=%02h",
                               " last=%0d empty=%0d dl=%08h"},
                              resp_count, want.status, want.expired_valid, want.expired_id,
                              want.last, want.queue_empty, want.earliest_deadline,
                              got.status, got.expired_valid, got.expired_id,
                              got.last, got.queue_empty, got.earliest_deadline);
               end
            end
            resp_count <= resp_count + 1;
            // quiet stretches: take responses back to back
            stall_left = ((resp_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
         end
         rsp_stall <= hold_on || (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // one long hold-off on the response side so that requests back up
   always @(posedge clock) begin
      if (reset) begin
         hold_on     <= 1'b0;
         hold_done   <= 1'b0;
         hold_cycles <= 0;
      end else if (!hold_done) begin
         if (!hold_on && resp_count >= HOLD_AFTER) begin
            hold_on <= 1'b1;
         end else if (hold_on) begin
            if (hold_cycles == HOLD_CYCLES) begin
               hold_on   <= 1'b0;
               hold_done <= 1'b1;
            end else begin
               hold_cycles <= hold_cycles + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void add_request(logic [1:0] op, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] tval, int gap, bit drain);
      timer_req_type r;
      r.op    = op;
      r.id    = id;
      r.tval  = tval;
      r.gap   = gap;
      r.drain = drain;
      req_backlog.push_back(r);
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      // mostly a small id set so that rearm and delete hit pending timers
      if ($urandom_range(0, 99) < 85) return ID_W'($urandom_range(0, 23));
      return ID_W'($urandom_range(0, 255));
   endfunction

   initial begin
      int roll;
      int gap;
      bit drain;
      logic [TIME_W-1:0] dl;

      // empty queue: idle tick, delete of an absent id, unused opcode, then creates at extreme values
      add_request(OP_TICK, 8'h00, 32'h0000_0000, $urandom_range(0, 3), 1'b0);
      add_request(OP_DELETE, 8'h00, 32'h0000_0000, $urandom_range(0, 3), 1'b0);
      add_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, $urandom_range(0, 3), 1'b0);
      add_request(OP_CREATE, 8'hFF, 32'hFFFF_FFFF, $urandom_range(0, 3), 1'b0);
      add_request(OP_CREATE, 8'h00, 32'h0000_0000, $urandom_range(0, 3), 1'b0);
      // equal deadlines keep arrival order
      add_request(OP_CREATE, 8'h55, 32'd100, $urandom_range(0, 3), 1'b0);
      add_request(OP_CREATE, 8'hAA, 32'd100, $urandom_range(0, 3), 1'b0);
      add_request(OP_CREATE, 8'h55, 32'd50, $urandom_range(0, 3), 1'b0);
      add_request(OP_TICK, 8'h00, 32'd99, $urandom_range(0, 3), 1'b0);
      add_request(OP_DELETE, 8'hAA, 32'h0, $urandom_range(0, 3), 1'b0);
      // fill the pool up to its depth
      for (int i = 1; i < POOL_DEPTH; i++)
         add_request(OP_CREATE, ID_W'(i), 32'd1000 + 32'((i % 4) * 10),
                     $urandom_range(0, 3), 1'b0);
      // full pool: new id refused, rearm of a present id accepted
      add_request(OP_CREATE, 8'hC8, 32'd10, $urandom_range(0, 3), 1'b0);
      add_request(OP_CREATE, 8'h03, 32'd500, $urandom_range(0, 3), 1'b0);
      // everything due at once
      add_request(OP_TICK, 8'h00, 32'hFFFF_FFFF, $urandom_range(0, 3), 1'b0);
      add_request(OP_TICK, 8'h5A, 32'h8000_0000, $urandom_range(0, 3), 1'b1);

      now_time      = 32'd2000;
      last_deadline = now_time;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         roll  = $urandom_range(0, 99);
         gap   = ((i / 30) % 3 == 1) ? 0 : $urandom_range(0, 3);
         drain = (i % 60 == 59);
         if ((i % 57) < 18 || roll < 40) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) dl = $urandom();
            else if (roll < 20) dl = last_deadline;
            else dl = now_time + 32'($urandom_range(0, 600));
            last_deadline = dl;
            add_request(OP_CREATE, pick_id(), dl, gap, drain);
         end else if (roll < 60) begin
            add_request(OP_DELETE, pick_id(), $urandom(), gap, drain);
         end else if (roll < 95) begin
            now_time = now_time + 32'($urandom_range(0, 250));
            if ($urandom_range(0, 99) < 8)
               add_request(OP_TICK, ID_W'($urandom()), $urandom(), gap, drain);
            else
               add_request(OP_TICK, ID_W'($urandom()), now_time, gap, drain);
         end else begin
            add_request(OP_UNUSED, ID_W'($urandom()), $urandom(), gap, drain);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || timer_outcomes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && timer_outcomes.size() == 0)
         $display("sorted_deadline_timer_queue verification clean");
      else
         $display("sorted_deadline_timer_queue verification failed");
      $finish;
   end

endmodule
